### hw/rtl/modbus_rtu_master_transaction_unit_defines.svh
// Assertion macros for the Modbus RTU master transaction unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef MODBUS_RTU_MASTER_TRANSACTION_UNIT_DEFINES_SVH
`define MODBUS_RTU_MASTER_TRANSACTION_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MRTU_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define MRTU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mrtu_pkg.sv
// Shared constants, types and the CRC-16 byte step of the Modbus RTU master.
// No dependencies.
`timescale 1ns / 1ps

package mrtu_pkg;

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam logic [7:0]  FUNC_READ     = 8'h03;
	localparam logic [7:0]  FUNC_WRITE1   = 8'h06;
	localparam logic [7:0]  FUNC_WRITEN   = 8'h10;
	localparam logic [7:0]  EXC_FLAG      = 8'h80;
	localparam logic [7:0]  MAX_READ      = 8'd125;
	localparam logic [7:0]  MAX_WRITE     = 8'd123;
	localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

	localparam logic [1:0] MODE_READ = 2'd0;
	localparam logic [1:0] MODE_WORD = 2'd1;
	localparam logic [1:0] MODE_RX   = 2'd2;
	localparam logic [1:0] MODE_TICK = 2'd3;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_WORD   = 2'd1;
	localparam logic [1:0] KIND_STATUS = 2'd2;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_BAD_REQ    = 3'd1;
	localparam logic [2:0] ST_TIMEOUT    = 3'd2;
	localparam logic [2:0] ST_ADDR_FUNC  = 3'd3;
	localparam logic [2:0] ST_BYTE_COUNT = 3'd4;
	localparam logic [2:0] ST_CRC        = 3'd5;
	localparam logic [2:0] ST_EXCEPTION  = 3'd6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		OP_STATUS,
		OP_WORD,
		OP_READ,
		OP_WRITE1,
		OP_WSTART,
		OP_WMORE
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t     op;
		logic [7:0]  addr;
		logic [15:0] start;
		logic [7:0]  count;
		logic [15:0] value;
		logic        last_word;
		logic [2:0]  st;
		logic [6:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Advance a reflected CRC-16 by one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

### hw/rtl/mrtu_ifs.sv
// Channel interfaces of the Modbus RTU master: request, result and config.
// No dependencies.
`timescale 1ns / 1ps

interface mrtu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [7:0]  slave_address;
	logic [15:0] start_address;
	logic [7:0]  register_count;
	logic [15:0] write_value;
	logic        value_last;
	logic [7:0]  rx_byte;
	modport source (output valid, mode, slave_address, start_address, register_count,
		write_value, value_last, rx_byte, input ready);
	modport sink (input valid, mode, slave_address, start_address, register_count,
		write_value, value_last, rx_byte, output ready);
endinterface

interface mrtu_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        frame_end;
	logic [15:0] reg_value;
	logic [6:0]  reg_index;
	logic [2:0]  status;
	logic        run_last;
	modport source (output valid, kind, tx_byte, frame_end, reg_value, reg_index, status,
		run_last, input ready);
	modport sink (input valid, kind, tx_byte, frame_end, reg_value, reg_index, status,
		run_last, output ready);
endinterface

interface mrtu_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### hw/rtl/mrtu_front.sv
// Front end: accepts requests, tracks the transaction and checks reply bytes.
// Depends on mrtu_pkg and mrtu_ifs; pushes commands into mrtu_cmd_queue.
`timescale 1ns / 1ps

module mrtu_front (
	input  logic                  clk,
	input  logic                  arst_n,
	mrtu_req_if.sink              req,
	mrtu_cfg_if.sink              cfg,
	output logic                  push,
	output mrtu_pkg::cmd_t        push_cmd,
	input  mrtu_pkg::queue_stat_t q_stat
);

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_COLLECT = 4'b0010,
		PH_WAIT    = 4'b0100,
		PH_EXC     = 4'b1000
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [15:0] timeout_q;
	logic [15:0] rxcrc_q, rxcrc_d;
	logic [7:0]  bc_q, bc_d;
	logic [6:0]  wc_q, wc_d;
	logic [7:0]  ea_q, ea_d;
	logic [7:0]  ef_q, ef_d;
	logic [6:0]  ec_q, ec_d;
	logic [15:0] sil_q, sil_d;
	logic [7:0]  held_q, held_d;
	logic [2:0]  lat_q, lat_d;

	logic        accept;
	logic        is_read;
	logic        exc_hit;
	logic [8:0]  len_base, len_eff, p9;
	logic [15:0] crc_fed;
	logic [16:0] tick_nxt;
	logic [6:0]  wc_inc;
	logic        busy_reply;

	assign req.ready = !q_stat.full;
	assign cfg.ready = 1'b1;
	assign accept    = req.valid && req.ready;

	// Reply framing terms
	assign is_read    = (ef_q == mrtu_pkg::FUNC_READ);
	assign busy_reply = (phase_q == PH_WAIT) || (phase_q == PH_EXC);
	assign len_base   = (phase_q == PH_EXC) ? 9'd5 :
		is_read ? (9'd5 + {1'b0, ec_q, 1'b0}) : 9'd8;
	assign exc_hit    = (bc_q == 8'd1) && (lat_q == mrtu_pkg::ST_OK) &&
		(req.rx_byte == (ef_q | mrtu_pkg::EXC_FLAG));
	assign len_eff    = exc_hit ? 9'd5 : len_base;
	assign p9         = {1'b0, bc_q};
	assign crc_fed    = mrtu_pkg::crc_byte(rxcrc_q, req.rx_byte);
	assign tick_nxt   = {1'b0, sil_q} + 17'd1;
	assign wc_inc     = wc_q + 7'd1;

	// Next state and command for one accepted item
	always_comb begin
		phase_d  = phase_q;
		rxcrc_d  = rxcrc_q;
		bc_d     = bc_q;
		wc_d     = wc_q;
		ea_d     = ea_q;
		ef_d     = ef_q;
		ec_d     = ec_q;
		sil_d    = sil_q;
		held_d   = held_q;
		lat_d    = lat_q;
		push     = 1'b0;
		push_cmd = '0;
		push_cmd.op    = mrtu_pkg::OP_STATUS;
		push_cmd.addr  = req.slave_address;
		push_cmd.start = req.start_address;
		push_cmd.count = req.register_count;
		push_cmd.value = req.write_value;
		if (accept) begin
			unique case (req.mode)
				mrtu_pkg::MODE_READ: begin
					if (phase_q == PH_IDLE) begin
						push = 1'b1;
						if (req.register_count == 8'd0 ||
							req.register_count > mrtu_pkg::MAX_READ) begin
							push_cmd.st = mrtu_pkg::ST_BAD_REQ;
						end else begin
							push_cmd.op = mrtu_pkg::OP_READ;
							ec_d    = req.register_count[6:0];
							ea_d    = req.slave_address;
							ef_d    = mrtu_pkg::FUNC_READ;
							phase_d = PH_WAIT;
							rxcrc_d = mrtu_pkg::CRC_INIT;
							bc_d    = '0;
							wc_d    = '0;
							sil_d   = '0;
							held_d  = '0;
							lat_d   = mrtu_pkg::ST_OK;
						end
					end
				end
				mrtu_pkg::MODE_WORD: begin
					if (phase_q == PH_IDLE) begin
						push = 1'b1;
						if (req.register_count == 8'd0 ||
							req.register_count > mrtu_pkg::MAX_WRITE) begin
							push_cmd.st = mrtu_pkg::ST_BAD_REQ;
						end else if (req.register_count == 8'd1) begin
							push_cmd.op = mrtu_pkg::OP_WRITE1;
							ec_d    = 7'd1;
							ea_d    = req.slave_address;
							ef_d    = mrtu_pkg::FUNC_WRITE1;
							phase_d = PH_WAIT;
							rxcrc_d = mrtu_pkg::CRC_INIT;
							bc_d    = '0;
							wc_d    = '0;
							sil_d   = '0;
							held_d  = '0;
							lat_d   = mrtu_pkg::ST_OK;
						end else if (req.value_last) begin
							push_cmd.st = mrtu_pkg::ST_BAD_REQ;
						end else begin
							push_cmd.op = mrtu_pkg::OP_WSTART;
							ec_d    = req.register_count[6:0];
							ea_d    = req.slave_address;
							ef_d    = mrtu_pkg::FUNC_WRITEN;
							wc_d    = 7'd1;
							phase_d = PH_COLLECT;
						end
					end else if (phase_q == PH_COLLECT) begin
						push = 1'b1;
						if (wc_inc < ec_q && req.value_last) begin
							// Early last word: drop the request
							push_cmd.st = mrtu_pkg::ST_BAD_REQ;
							phase_d     = PH_IDLE;
							wc_d        = '0;
						end else begin
							push_cmd.op        = mrtu_pkg::OP_WMORE;
							push_cmd.last_word = (wc_inc >= ec_q);
							if (wc_inc >= ec_q) begin
								phase_d = PH_WAIT;
								rxcrc_d = mrtu_pkg::CRC_INIT;
								bc_d    = '0;
								wc_d    = '0;
								sil_d   = '0;
								held_d  = '0;
								lat_d   = mrtu_pkg::ST_OK;
							end else begin
								wc_d = wc_inc;
							end
						end
					end
				end
				mrtu_pkg::MODE_RX: begin
					if (busy_reply) begin
						sil_d = '0;
						if ((p9 + 9'd2) < len_base) begin
							rxcrc_d = crc_fed;
						end
						if (bc_q == 8'd0) begin
							if (req.rx_byte != ea_q) lat_d = mrtu_pkg::ST_ADDR_FUNC;
						end else if (bc_q == 8'd1) begin
							if (lat_q == mrtu_pkg::ST_OK) begin
								if (exc_hit) phase_d = PH_EXC;
								else if (req.rx_byte != ef_q) lat_d = mrtu_pkg::ST_ADDR_FUNC;
							end
						end else if (bc_q == 8'd2 && phase_q == PH_WAIT && is_read) begin
							if (lat_q == mrtu_pkg::ST_OK && req.rx_byte != {ec_q, 1'b0}) begin
								lat_d = mrtu_pkg::ST_BYTE_COUNT;
							end
						end else if ((p9 + 9'd2) < len_eff && phase_q == PH_WAIT && is_read) begin
							if (bc_q[0]) begin
								held_d = req.rx_byte;
							end else begin
								push           = 1'b1;
								push_cmd.op    = mrtu_pkg::OP_WORD;
								push_cmd.value = {held_q, req.rx_byte};
								push_cmd.idx   = wc_q;
								wc_d           = wc_inc;
							end
						end
						// Hold the CRC low byte, then close the reply on its last byte
						if ((p9 + 9'd2) == len_eff) begin
							held_d = req.rx_byte;
							bc_d   = bc_q + 8'd1;
						end else if ((p9 + 9'd1) == len_eff) begin
							push = 1'b1;
							if (lat_q != mrtu_pkg::ST_OK) push_cmd.st = lat_q;
							else if (phase_q == PH_EXC) push_cmd.st = mrtu_pkg::ST_EXCEPTION;
							else if (rxcrc_q == {req.rx_byte, held_q}) push_cmd.st = mrtu_pkg::ST_OK;
							else push_cmd.st = mrtu_pkg::ST_CRC;
							phase_d = PH_IDLE;
							bc_d    = '0;
						end else begin
							bc_d = bc_q + 8'd1;
						end
					end
				end
				mrtu_pkg::MODE_TICK: begin
					if (busy_reply) begin
						if (tick_nxt > {1'b0, timeout_q}) begin
							push        = 1'b1;
							push_cmd.st = mrtu_pkg::ST_TIMEOUT;
							phase_d     = PH_IDLE;
							bc_d        = '0;
							sil_d       = '0;
						end else begin
							sil_d = tick_nxt[15:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold configuration and transaction state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= mrtu_pkg::TIMEOUT_RESET;
			phase_q   <= PH_IDLE;
			rxcrc_q   <= mrtu_pkg::CRC_INIT;
			bc_q      <= '0;
			wc_q      <= '0;
			ea_q      <= '0;
			ef_q      <= '0;
			ec_q      <= '0;
			sil_q     <= '0;
			held_q    <= '0;
			lat_q     <= mrtu_pkg::ST_OK;
		end else begin
			if (cfg.valid) timeout_q <= cfg.data;
			phase_q <= phase_d;
			rxcrc_q <= rxcrc_d;
			bc_q    <= bc_d;
			wc_q    <= wc_d;
			ea_q    <= ea_d;
			ef_q    <= ef_d;
			ec_q    <= ec_d;
			sil_q   <= sil_d;
			held_q  <= held_d;
			lat_q   <= lat_d;
		end
	end

endmodule

### hw/rtl/mrtu_cmd_queue.sv
// Short command queue between the front end and the result sequencer.
// Depends on mrtu_pkg.
`timescale 1ns / 1ps

module mrtu_cmd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mrtu_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output mrtu_pkg::cmd_t        pop_cmd,
	output mrtu_pkg::queue_stat_t q_stat
);

	mrtu_pkg::cmd_t                mem_q [mrtu_pkg::QUEUE_DEPTH];
	logic [mrtu_pkg::QUEUE_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [mrtu_pkg::QUEUE_AW:0]   count_q;

	assign q_stat.full  = (count_q == (mrtu_pkg::QUEUE_AW + 1)'(mrtu_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_cmd      = mem_q[rd_ptr_q];

	// Store pushed commands
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_cmd;
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			priority if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

### hw/rtl/mrtu_back.sv
// Result sequencer: expands commands into result items, one per cycle unless the
// result channel stalls, and appends the transmit CRC. Depends on mrtu_pkg and mrtu_ifs.
`timescale 1ns / 1ps

module mrtu_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mrtu_pkg::queue_stat_t q_stat,
	input  mrtu_pkg::cmd_t        pop_cmd,
	output logic                  pop,
	mrtu_res_if.source            res
);

	mrtu_pkg::cmd_t cur_q;
	logic           cur_valid_q;
	logic [3:0]     step_q;
	logic [15:0]    crc_q;

	logic [3:0]  n_last;
	logic        last_step;
	logic        emit;
	logic [7:0]  tx_b;
	logic        crc_lo, crc_hi;
	logic        frame_start;
	logic [15:0] crc_base;

	// Last step index per command
	always_comb begin
		unique case (cur_q.op)
			mrtu_pkg::OP_STATUS, mrtu_pkg::OP_WORD: n_last = 4'd0;
			mrtu_pkg::OP_READ, mrtu_pkg::OP_WRITE1: n_last = 4'd7;
			mrtu_pkg::OP_WSTART:                    n_last = 4'd8;
			mrtu_pkg::OP_WMORE:                     n_last = cur_q.last_word ? 4'd3 : 4'd1;
			default:                                n_last = 4'd0;
		endcase
	end

	assign last_step = (step_q == n_last);
	assign emit      = cur_valid_q && (!res.valid || res.ready);
	assign pop       = !q_stat.empty && (!cur_valid_q || (emit && last_step));

	// Select the frame byte for this step
	always_comb begin
		tx_b   = 8'h00;
		crc_lo = 1'b0;
		crc_hi = 1'b0;
		if (cur_q.op == mrtu_pkg::OP_WMORE) begin
			unique case (step_q)
				4'd0:    tx_b = cur_q.value[15:8];
				4'd1:    tx_b = cur_q.value[7:0];
				4'd2:    crc_lo = 1'b1;
				default: crc_hi = 1'b1;
			endcase
		end else begin
			unique case (step_q)
				4'd0: tx_b = cur_q.addr;
				4'd1: begin
					priority if (cur_q.op == mrtu_pkg::OP_READ) tx_b = mrtu_pkg::FUNC_READ;
					else if (cur_q.op == mrtu_pkg::OP_WRITE1) tx_b = mrtu_pkg::FUNC_WRITE1;
					else tx_b = mrtu_pkg::FUNC_WRITEN;
				end
				4'd2: tx_b = cur_q.start[15:8];
				4'd3: tx_b = cur_q.start[7:0];
				4'd4: tx_b = (cur_q.op == mrtu_pkg::OP_WRITE1) ? cur_q.value[15:8] : 8'h00;
				4'd5: tx_b = (cur_q.op == mrtu_pkg::OP_WRITE1) ? cur_q.value[7:0] : cur_q.count;
				4'd6: begin
					if (cur_q.op == mrtu_pkg::OP_WSTART) tx_b = {cur_q.count[6:0], 1'b0};
					else crc_lo = 1'b1;
				end
				4'd7: begin
					if (cur_q.op == mrtu_pkg::OP_WSTART) tx_b = cur_q.value[15:8];
					else crc_hi = 1'b1;
				end
				default: tx_b = cur_q.value[7:0];
			endcase
		end
	end

	assign frame_start = (step_q == 4'd0) && (cur_q.op == mrtu_pkg::OP_READ ||
		cur_q.op == mrtu_pkg::OP_WRITE1 || cur_q.op == mrtu_pkg::OP_WSTART);
	assign crc_base    = frame_start ? mrtu_pkg::CRC_INIT : crc_q;

	// Hold the current command and walk its steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			step_q      <= '0;
			crc_q       <= mrtu_pkg::CRC_INIT;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				step_q      <= '0;
			end else if (emit && last_step) begin
				cur_valid_q <= 1'b0;
			end else if (emit) begin
				step_q <= step_q + 4'd1;
			end
			if (emit && (cur_q.op != mrtu_pkg::OP_STATUS) && (cur_q.op != mrtu_pkg::OP_WORD) &&
				!crc_lo && !crc_hi) begin
				crc_q <= mrtu_pkg::crc_byte(crc_base, tx_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= pop_cmd;
	end

	// Drive the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (emit) begin
			res.valid <= 1'b1;
		end else if (res.ready) begin
			res.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res.kind      <= mrtu_pkg::KIND_TX;
			res.tx_byte   <= 8'h00;
			res.frame_end <= 1'b0;
			res.reg_value <= 16'h0000;
			res.reg_index <= 7'd0;
			res.status    <= mrtu_pkg::ST_OK;
			res.run_last  <= last_step;
			priority if (cur_q.op == mrtu_pkg::OP_STATUS) begin
				res.kind   <= mrtu_pkg::KIND_STATUS;
				res.status <= cur_q.st;
			end else if (cur_q.op == mrtu_pkg::OP_WORD) begin
				res.kind      <= mrtu_pkg::KIND_WORD;
				res.reg_value <= cur_q.value;
				res.reg_index <= cur_q.idx;
			end else if (crc_lo) begin
				res.tx_byte <= crc_q[7:0];
			end else if (crc_hi) begin
				res.tx_byte   <= crc_q[15:8];
				res.frame_end <= 1'b1;
			end else begin
				res.tx_byte <= tx_b;
			end
		end
	end

endmodule

### hw/rtl/modbus_rtu_master_transaction_unit.sv
// Modbus RTU master transaction unit: top level joining front end, command
// queue and result sequencer. Depends on mrtu_pkg, mrtu_ifs and the defines header.
`timescale 1ns / 1ps
`include "modbus_rtu_master_transaction_unit_defines.svh"

// The front end takes one item per cycle while its four-entry command queue has
// room; each item becomes at most one command. The result sequencer then emits
// one result per cycle while res.ready does not stall it: a read or single-write
// request yields 8 results, the first word of a multiple write 9, later words 2
// (4 on the final word with the CRC), and a reply byte or tick 1 when it yields a
// register word or a status, none otherwise. The sequencer's one-result-per-cycle
// output register sets the sustained rate. No clearing pass after reset.
module modbus_rtu_master_transaction_unit (
	input  logic       clk,
	input  logic       arst_n,
	mrtu_req_if.sink   req,
	mrtu_cfg_if.sink   cfg,
	mrtu_res_if.source res
);

	logic                  q_push;
	logic                  q_pop;
	mrtu_pkg::cmd_t        q_push_cmd;
	mrtu_pkg::cmd_t        q_pop_cmd;
	mrtu_pkg::queue_stat_t q_stat;

	mrtu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.q_stat   (q_stat)
	);

	mrtu_cmd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_push_cmd),
		.pop      (q_pop),
		.pop_cmd  (q_pop_cmd),
		.q_stat   (q_stat)
	);

	mrtu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_stat  (q_stat),
		.pop_cmd (q_pop_cmd),
		.pop     (q_pop),
		.res     (res)
	);

	// Queue and output checks
	`MRTU_ASSERT_IMPL(a_no_push_full, q_push, !q_stat.full, "command pushed into full queue")
	`MRTU_ASSERT_NEXT(a_push_fills, q_push, !q_stat.empty, "pushed command lost")
	`MRTU_ASSERT_IMPL(a_stall_full, !req.ready, q_stat.full, "request stalled with queue room")
	`MRTU_ASSERT_IMPL(a_frame_end_tx, res.valid && res.frame_end, res.kind == mrtu_pkg::KIND_TX && res.run_last, "frame end on wrong result")

endmodule

### bench/modbus_rtu_master_transaction_unit_tb.sv
// Self-checking bench for the Modbus RTU master transaction unit: builds request
// and reply traffic, predicts every result and checks it on the result channel.
// Depends on mrtu_pkg, mrtu_ifs and the top level modbus_rtu_master_transaction_unit.
`timescale 1ns / 1ps

module modbus_rtu_master_transaction_unit_tb;

	typedef struct {
		logic [1:0]  mode;
		logic [7:0]  slave_address;
		logic [15:0] start_address;
		logic [7:0]  register_count;
		logic [15:0] write_value;
		logic        value_last;
		logic [7:0]  rx_byte;
	} req_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  tx_byte;
		logic        frame_end;
		logic [15:0] reg_value;
		logic [6:0]  reg_index;
		logic [2:0]  status;
		logic        run_last;
	} res_item_t;

	typedef enum logic [1:0] {PH_IDLE, PH_WORDS, PH_REPLY, PH_EXC} phase_t;

	// Reply corruption choices
	typedef enum int {RP_GOOD, RP_ADDR, RP_FUNC, RP_COUNT, RP_CRC, RP_EXC, RP_SILENT,
		RP_NOISE} reply_err_t;

	// Transaction predictor and store of expected results
	class mrtu_scoreboard;
		logic [15:0] timeout_ticks;
		phase_t      ph;
		logic [15:0] crc;
		int          bytes_seen;
		int          words_seen;
		logic [7:0]  exp_addr;
		logic [7:0]  exp_func;
		int          exp_count;
		int          silence;
		logic [7:0]  held;
		logic [2:0]  err;
		res_item_t   awaited[$];
		int          errors;
		int          checked;

		function new();
			timeout_ticks = mrtu_pkg::TIMEOUT_RESET;
			ph = PH_IDLE;
			crc = mrtu_pkg::CRC_INIT;
			bytes_seen = 0;
			words_seen = 0;
			exp_addr = '0;
			exp_func = '0;
			exp_count = 0;
			silence = 0;
			held = '0;
			err = mrtu_pkg::ST_OK;
			errors = 0;
			checked = 0;
		endfunction

		static function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ mrtu_pkg::CRC_POLY) : (r >> 1);
			return r;
		endfunction

		function void push(logic [1:0] k, logic [7:0] tx, logic fe, logic [15:0] v,
				logic [6:0] idx, logic [2:0] st);
			res_item_t r;
			r.kind = k;
			r.tx_byte = tx;
			r.frame_end = fe;
			r.reg_value = v;
			r.reg_index = idx;
			r.status = st;
			r.run_last = 1'b0;
			awaited.push_back(r);
		endfunction

		function void send_byte(logic [7:0] b);
			crc = crc_step(crc, b);
			push(mrtu_pkg::KIND_TX, b, 1'b0, '0, '0, mrtu_pkg::ST_OK);
		endfunction

		function void close_frame();
			push(mrtu_pkg::KIND_TX, crc[7:0], 1'b0, '0, '0, mrtu_pkg::ST_OK);
			push(mrtu_pkg::KIND_TX, crc[15:8], 1'b1, '0, '0, mrtu_pkg::ST_OK);
			ph = PH_REPLY;
			crc = mrtu_pkg::CRC_INIT;
			bytes_seen = 0;
			words_seen = 0;
			silence = 0;
			held = '0;
			err = mrtu_pkg::ST_OK;
		endfunction

		function void open_frame(logic [7:0] a, logic [7:0] f, logic [15:0] sa);
			crc = mrtu_pkg::CRC_INIT;
			exp_addr = a;
			exp_func = f;
			send_byte(a);
			send_byte(f);
			send_byte(sa[15:8]);
			send_byte(sa[7:0]);
		endfunction

		// Advance the prediction by one accepted request
		function void note_request(req_item_t it);
			int base;
			int p;
			int len;
			bit is_read;
			logic [2:0] st;
			base = awaited.size();
			case (it.mode)
				mrtu_pkg::MODE_READ: begin
					if (ph == PH_IDLE) begin
						if (it.register_count == 0 ||
							it.register_count > mrtu_pkg::MAX_READ) begin
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0,
								mrtu_pkg::ST_BAD_REQ);
						end else begin
							exp_count = it.register_count;
							open_frame(it.slave_address, mrtu_pkg::FUNC_READ,
								it.start_address);
							send_byte(8'h00);
							send_byte(it.register_count);
							close_frame();
						end
					end
				end
				mrtu_pkg::MODE_WORD: begin
					if (ph == PH_IDLE) begin
						if (it.register_count == 0 ||
							it.register_count > mrtu_pkg::MAX_WRITE) begin
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0,
								mrtu_pkg::ST_BAD_REQ);
						end else if (it.register_count == 1) begin
							exp_count = 1;
							open_frame(it.slave_address, mrtu_pkg::FUNC_WRITE1,
								it.start_address);
							send_byte(it.write_value[15:8]);
							send_byte(it.write_value[7:0]);
							close_frame();
						end else if (it.value_last) begin
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0,
								mrtu_pkg::ST_BAD_REQ);
						end else begin
							exp_count = it.register_count;
							open_frame(it.slave_address, mrtu_pkg::FUNC_WRITEN,
								it.start_address);
							send_byte(8'h00);
							send_byte(it.register_count);
							send_byte(8'(2 * it.register_count));
							send_byte(it.write_value[15:8]);
							send_byte(it.write_value[7:0]);
							words_seen = 1;
							ph = PH_WORDS;
						end
					end else if (ph == PH_WORDS) begin
						if (words_seen + 1 < exp_count && it.value_last) begin
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0,
								mrtu_pkg::ST_BAD_REQ);
							ph = PH_IDLE;
							words_seen = 0;
						end else begin
							send_byte(it.write_value[15:8]);
							send_byte(it.write_value[7:0]);
							words_seen = (words_seen + 1) & 8'h7F;
							if (words_seen >= exp_count)
								close_frame();
						end
					end
				end
				mrtu_pkg::MODE_RX: begin
					if (ph == PH_REPLY || ph == PH_EXC) begin
						p = bytes_seen;
						is_read = (exp_func == mrtu_pkg::FUNC_READ);
						silence = 0;
						if (ph == PH_EXC)
							len = 5;
						else if (is_read)
							len = 5 + 2 * exp_count;
						else
							len = 8;
						if (p + 2 < len)
							crc = crc_step(crc, it.rx_byte);
						// Header checks, then the data words of a read
						if (p == 0) begin
							if (it.rx_byte != exp_addr)
								err = mrtu_pkg::ST_ADDR_FUNC;
						end else if (p == 1) begin
							if (err == mrtu_pkg::ST_OK) begin
								if (it.rx_byte == (exp_func | mrtu_pkg::EXC_FLAG)) begin
									ph = PH_EXC;
									len = 5;
								end else if (it.rx_byte != exp_func) begin
									err = mrtu_pkg::ST_ADDR_FUNC;
								end
							end
						end else if (p == 2 && ph == PH_REPLY && is_read) begin
							if (err == mrtu_pkg::ST_OK && it.rx_byte != 2 * exp_count)
								err = mrtu_pkg::ST_BYTE_COUNT;
						end else if (p + 2 < len && ph == PH_REPLY && is_read) begin
							if (((p - 3) & 1) == 0) begin
								held = it.rx_byte;
							end else begin
								push(mrtu_pkg::KIND_WORD, '0, 1'b0, {held, it.rx_byte},
									7'(words_seen), mrtu_pkg::ST_OK);
								words_seen = (words_seen + 1) & 8'h7F;
							end
						end
						// Trailer: hold the CRC low byte, finish on the high byte
						if (p + 2 == len) begin
							held = it.rx_byte;
							bytes_seen = (p + 1) & 8'hFF;
						end else if (p + 1 == len) begin
							if (err != mrtu_pkg::ST_OK)
								st = err;
							else if (ph == PH_EXC)
								st = mrtu_pkg::ST_EXCEPTION;
							else if (crc == {it.rx_byte, held})
								st = mrtu_pkg::ST_OK;
							else
								st = mrtu_pkg::ST_CRC;
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0, st);
							ph = PH_IDLE;
							bytes_seen = 0;
						end else begin
							bytes_seen = (p + 1) & 8'hFF;
						end
					end
				end
				default: begin
					if (ph == PH_REPLY || ph == PH_EXC) begin
						if (silence + 1 > timeout_ticks) begin
							push(mrtu_pkg::KIND_STATUS, '0, 1'b0, '0, '0,
								mrtu_pkg::ST_TIMEOUT);
							ph = PH_IDLE;
							bytes_seen = 0;
							silence = 0;
						end else begin
							silence = silence + 1;
						end
					end
				end
			endcase
			if (awaited.size() > base)
				awaited[awaited.size() - 1].run_last = 1'b1;
		endfunction

		function void cmp(string name, int e, int a);
			if (e != a) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		// Compare one accepted result with the oldest expectation
		function void check_result(res_item_t act);
			res_item_t e;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual kind %0d", $time,
					act.kind);
				errors++;
				return;
			end
			e = awaited.pop_front();
			checked++;
			cmp("kind", e.kind, act.kind);
			cmp("tx_byte", e.tx_byte, act.tx_byte);
			cmp("frame_end", e.frame_end, act.frame_end);
			cmp("reg_value", e.reg_value, act.reg_value);
			cmp("reg_index", e.reg_index, act.reg_index);
			cmp("status", e.status, act.status);
			cmp("run_last", e.run_last, act.run_last);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	mrtu_req_if req ();
	mrtu_cfg_if cfg ();
	mrtu_res_if res ();

	modbus_rtu_master_transaction_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.cfg    (cfg.sink),
		.res    (res.source)
	);

	mrtu_scoreboard sb = new();

	int burst_left = 0;
	int items_used = 0;
	int reads_done = 0;
	int writes_done = 0;
	int cfg_writes = 0;
	int stall_style = 0;
	int stall_cnt = 0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Result side: check accepted results, stall on a shifting pattern
	always @(posedge clk) begin
		res_item_t r;
		if (arst_n) begin
			if (res.valid && res.ready) begin
				r.kind = res.kind;
				r.tx_byte = res.tx_byte;
				r.frame_end = res.frame_end;
				r.reg_value = res.reg_value;
				r.reg_index = res.reg_index;
				r.status = res.status;
				r.run_last = res.run_last;
				sb.check_result(r);
			end
			stall_cnt++;
			if (stall_cnt % 48 == 0)
				stall_style = $urandom_range(0, 3);
			case (stall_style)
				0: res.ready <= 1'b1;
				1: res.ready <= 1'($urandom_range(0, 1));
				2: res.ready <= (stall_cnt % 4 == 0);
				default: res.ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic req_item_t rand_item(logic [1:0] m);
		req_item_t it;
		it.mode = m;
		it.slave_address = 8'($urandom_range(0, 255));
		it.start_address = 16'($urandom_range(0, 65535));
		it.register_count = 8'($urandom_range(0, 255));
		it.write_value = 16'($urandom_range(0, 65535));
		it.value_last = 1'($urandom_range(0, 1));
		it.rx_byte = 8'($urandom_range(0, 255));
		return it;
	endfunction

	// Offer one request in bursts with random gaps, note it once accepted
	task automatic drive(req_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		req.valid <= 1'b1;
		req.mode <= it.mode;
		req.slave_address <= it.slave_address;
		req.start_address <= it.start_address;
		req.register_count <= it.register_count;
		req.write_value <= it.write_value;
		req.value_last <= it.value_last;
		req.rx_byte <= it.rx_byte;
		do @(posedge clk); while (!req.ready);
		if (it.mode == mrtu_pkg::MODE_READ || it.mode == mrtu_pkg::MODE_WORD) begin
			if (sb.ph == PH_IDLE || (it.mode == mrtu_pkg::MODE_WORD && sb.ph == PH_WORDS))
				items_used++;
		end else if (sb.ph == PH_REPLY || sb.ph == PH_EXC) begin
			items_used++;
		end
		sb.note_request(it);
		burst_left--;
	endtask

	task automatic drive_rx(logic [7:0] b);
		req_item_t it;
		it = rand_item(mrtu_pkg::MODE_RX);
		it.rx_byte = b;
		drive(it);
	endtask

	// Write the timeout register once all expected results are out
	task automatic write_timeout(logic [15:0] v);
		req.valid <= 1'b0;
		burst_left = 0;
		while (sb.awaited.size() != 0) @(posedge clk);
		repeat (24) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= v;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		sb.timeout_ticks = v;
		cfg_writes++;
	endtask

	// Answer a pending request: well formed or broken as asked
	task automatic answer(reply_err_t how);
		logic [7:0] frame[$];
		logic [15:0] c;
		int k;
		frame.push_back(sb.exp_addr);
		if (how == RP_EXC) begin
			frame.push_back(sb.exp_func | mrtu_pkg::EXC_FLAG);
			frame.push_back(8'($urandom_range(1, 11)));
		end else if (sb.exp_func == mrtu_pkg::FUNC_READ) begin
			frame.push_back(mrtu_pkg::FUNC_READ);
			frame.push_back(8'(2 * sb.exp_count));
			for (int i = 0; i < 2 * sb.exp_count; i++)
				frame.push_back(8'($urandom_range(0, 255)));
		end else begin
			frame.push_back(sb.exp_func);
			for (int i = 0; i < 4; i++)
				frame.push_back(8'($urandom_range(0, 255)));
		end
		c = mrtu_pkg::CRC_INIT;
		foreach (frame[i])
			c = mrtu_scoreboard::crc_step(c, frame[i]);
		frame.push_back(c[7:0]);
		frame.push_back(c[15:8]);
		case (how)
			RP_ADDR: frame[0] = frame[0] ^ 8'($urandom_range(1, 255));
			RP_FUNC: frame[1] = ($urandom_range(0, 1)) ? 8'h7F : frame[1] ^ 8'h01;
			RP_COUNT: if (sb.exp_func == mrtu_pkg::FUNC_READ)
				frame[2] = frame[2] ^ 8'($urandom_range(1, 255));
			RP_CRC: frame[frame.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
			default: ;
		endcase
		if (how == RP_NOISE) begin
			k = 0;
			while (sb.ph != PH_IDLE && k < 300) begin
				drive_rx(8'($urandom_range(0, 255)));
				k++;
			end
		end else if (how == RP_SILENT) begin
			k = $urandom_range(0, frame.size() - 1);
			for (int i = 0; i < k; i++)
				drive_rx(frame[i]);
			while (sb.ph != PH_IDLE)
				drive(rand_item(mrtu_pkg::MODE_TICK));
		end else begin
			foreach (frame[i]) begin
				if (sb.ph == PH_IDLE)
					break;
				// Keep silence under the limit: one tick at most per gap
				if ($urandom_range(0, 5) == 0)
					drive(rand_item(mrtu_pkg::MODE_TICK));
				if ($urandom_range(0, 15) == 0)
					drive(rand_item(2'($urandom_range(0, 1))));
				drive_rx(frame[i]);
			end
		end
	endtask

	function automatic reply_err_t pick_reply();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return RP_GOOD;
		if (r < 57) return RP_ADDR;
		if (r < 64) return RP_FUNC;
		if (r < 71) return RP_COUNT;
		if (r < 79) return RP_CRC;
		if (r < 87) return RP_EXC;
		if (r < 94 && sb.timeout_ticks <= 50) return RP_SILENT;
		return RP_NOISE;
	endfunction

	task automatic do_read(int n, reply_err_t how);
		req_item_t it;
		it = rand_item(mrtu_pkg::MODE_READ);
		it.register_count = 8'(n);
		drive(it);
		reads_done++;
		if (sb.ph != PH_IDLE)
			answer(how);
	endtask

	// Multiple or single write; abort_at from 1 to n-2 closes the request early
	task automatic do_write(int n, int abort_at, reply_err_t how);
		req_item_t it;
		for (int i = 0; i < n; i++) begin
			it = rand_item(mrtu_pkg::MODE_WORD);
			if (i == 0) begin
				it.register_count = 8'(n);
				it.value_last = (n == 1) ? it.value_last : 1'b0;
			end else if (i == n - 1) begin
				it.value_last = 1'($urandom_range(0, 1));
			end else begin
				it.value_last = (i == abort_at);
			end
			if (i > 0 && $urandom_range(0, 9) == 0)
				drive(rand_item($urandom_range(0, 1) ? mrtu_pkg::MODE_RX :
					mrtu_pkg::MODE_TICK));
			drive(it);
			if (sb.ph == PH_IDLE)
				break;
		end
		writes_done++;
		if (sb.ph == PH_REPLY)
			answer(how);
	endtask

	task automatic random_traffic(int target);
		int r;
		int n;
		req_item_t it;
		while (items_used < target) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 125) : $urandom_range(1, 4);
				do_read(n, pick_reply());
			end else if (r < 75) begin
				n = ($urandom_range(0, 29) == 0) ? $urandom_range(7, 123) : $urandom_range(1, 6);
				do_write(n, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 200,
					pick_reply());
			end else if (r < 85) begin
				it = rand_item(2'($urandom_range(0, 1)));
				it.register_count = ($urandom_range(0, 2) == 0) ? 8'd0 :
					8'($urandom_range(126, 255));
				drive(it);
			end else begin
				drive(rand_item(2'($urandom_range(2, 3))));
			end
		end
	endtask

	initial begin
		req_item_t it;
		int waited;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.mode = mrtu_pkg::MODE_TICK;
		req.slave_address = '0;
		req.start_address = '0;
		req.register_count = '0;
		req.write_value = '0;
		req.value_last = 1'b0;
		req.rx_byte = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		res.ready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: bad counts at both edges, stray input, a clean read, a single write answered with an exception
		it = rand_item(mrtu_pkg::MODE_READ);
		it.register_count = 0;
		drive(it);
		it.register_count = 126;
		drive(it);
		it = rand_item(mrtu_pkg::MODE_WORD);
		it.register_count = 0;
		drive(it);
		it.register_count = 124;
		drive(it);
		it.register_count = 255;
		drive(it);
		it.register_count = 2;
		it.value_last = 1'b1;
		drive(it);
		drive(rand_item(mrtu_pkg::MODE_RX));
		drive(rand_item(mrtu_pkg::MODE_TICK));
		do_read(1, RP_GOOD);
		do_write(1, 200, RP_EXC);

		// Random phases over several timeout settings, extremes included
		random_traffic(90);
		write_timeout(16'd1);
		random_traffic(150);
		write_timeout(16'hFFFF);
		do_read(125, RP_EXC);
		do_write(123, 40, RP_GOOD);
		random_traffic(250);
		write_timeout(16'd6);
		random_traffic(310);

		req.valid <= 1'b0;
		waited = 0;
		while (sb.awaited.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (sb.awaited.size() != 0) begin
			$display("%0t: %0d results never arrived, expected none left, actual %0d",
				$time, sb.awaited.size(), sb.awaited.size());
			sb.errors++;
		end
		$display("Covered %0d reads, %0d writes, %0d timeout writes, %0d used inputs,",
			reads_done, writes_done, cfg_writes, items_used);
		$display("with %0d results checked and %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("modbus_rtu_master_transaction_unit test passed");
		else
			$display("modbus_rtu_master_transaction_unit test failed");
		$finish;
	end

	// Hard stop on a hang
	initial begin
		#4_000_000;
		$display("modbus_rtu_master_transaction_unit test failed");
		$finish;
	end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_ifs.sv
hw/rtl/mrtu_front.sv
hw/rtl/mrtu_cmd_queue.sv
hw/rtl/mrtu_back.sv
hw/rtl/modbus_rtu_master_transaction_unit.sv
bench/modbus_rtu_master_transaction_unit_tb.sv
